[rtl/lcdl_pkg.sv]
// Shared types, constants and the sine table generator for the chorus delay line.
`default_nettype none

package lcdl_pkg;

   // Default sizes; both must be powers of two
   localparam int unsigned DELAY_DEPTH_DEF  = 4096;
   localparam int unsigned SINE_ENTRIES_DEF = 1024;

   // Field and register widths
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned PHASE_W    = 32;
   localparam int unsigned INC_W      = 20;
   localparam int unsigned DLYCFG_W   = 20;
   localparam int unsigned WET_W      = 17;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned SINE_MAG_W = 15;

   // Fully wet share
   localparam logic [WET_W-1:0] WET_FULL = 17'd65536;

   // Serial multiplier: signed 17-bit multiplicand, unsigned multiplier consumed
   // two bits per cycle from the top of a 20-bit shift register
   localparam int unsigned MUL_A_W   = 17;
   localparam int unsigned MUL_A3_W  = 19;
   localparam int unsigned MUL_B_W   = 20;
   localparam int unsigned MUL_CNT_W = 4;
   localparam int unsigned ACC_W     = 38;

   localparam logic [MUL_CNT_W-1:0] MOD_DIGITS    = 4'd10;
   localparam logic [MUL_CNT_W-1:0] INTERP_DIGITS = 4'd4;
   localparam logic [MUL_CNT_W-1:0] FBK_DIGITS    = 4'd8;
   localparam logic [MUL_CNT_W-1:0] MIX_DIGITS    = 4'd9;

   // Two pi in Q29
   localparam logic [63:0] TURN_Q29 = 64'd3373259426;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_INC = 3'd0,
      CSR_BASE_DLY  = 3'd1,
      CSR_MOD_DEPTH = 3'd2,
      CSR_WET_MIX   = 3'd3,
      CSR_FBK_GAIN  = 3'd4,
      CSR_EFFECT_ON = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SINE,
      ST_LOAD,
      ST_MUL,
      ST_DELAY,
      ST_RD1,
      ST_RD2,
      ST_DIFF,
      ST_TAP,
      ST_FBK,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MOP_MOD,
      MOP_INTERP,
      MOP_FBK,
      MOP_MIX
   } mul_op_type;

   // Magnitude of the sine point at quarter-wave index idx of a 2**log2n table.
   // Evaluated at elaboration only (constant arguments).
   function automatic logic [SINE_MAG_W-1:0] sine_mag(input int unsigned idx,
                                                      input int unsigned log2n);
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      r;
      u    = 64'(idx) << (32 - log2n);
      x    = (u * TURN_Q29) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return r[SINE_MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/lfo_chorus_delay_line_unit.sv]
// Chorus delay line: LFO-modulated fractional delay with feedback and dry/wet mix.
// Effect on: the sample is processed by the shared two-bit-per-cycle multiplier and two ring reads,
//   one item at a time; the next input is taken once the result is in the output register.
// Effect off: the sample passes through the result register to the output register, one item at a time.
// Reset (synchronous): clears control and configuration registers, LFO phase and write pointer;
//   the ring is not swept, entries not written since reset read as zero through a written-region check.
`default_nettype none

module lfo_chorus_delay_line_unit #(
   parameter int unsigned DELAY_DEPTH  = lcdl_pkg::DELAY_DEPTH_DEF,
   parameter int unsigned SINE_ENTRIES = lcdl_pkg::SINE_ENTRIES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [lcdl_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [lcdl_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                                    csr_write_en,
   input  logic [lcdl_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [lcdl_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int unsigned ADDR_W   = $clog2(DELAY_DEPTH);
   localparam int unsigned LOG2N    = $clog2(SINE_ENTRIES);
   localparam int unsigned SINE_QTR = SINE_ENTRIES / 4;
   localparam int unsigned QTR_W    = LOG2N - 2;
   localparam int unsigned DLY_W    = ADDR_W + 8;
   localparam int unsigned SUM_W    = (ADDR_W + 10 > 23) ? ADDR_W + 10 : 23;
   localparam int unsigned SW       = lcdl_pkg::SAMPLE_W;
   localparam int unsigned AW       = lcdl_pkg::MUL_A_W;
   localparam int unsigned A3W      = lcdl_pkg::MUL_A3_W;
   localparam int unsigned BW       = lcdl_pkg::MUL_B_W;
   localparam int unsigned ACC_W    = lcdl_pkg::ACC_W;

   localparam logic signed [SUM_W-1:0] DMAX  = SUM_W'((DELAY_DEPTH - 2) * 256);
   localparam logic signed [ACC_W-1:0] RND8  = ACC_W'(128);
   localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
   localparam logic [lcdl_pkg::SINE_MAG_W-1:0] SINE_PEAK =
      lcdl_pkg::sine_mag(SINE_QTR, LOG2N);

   // Saturate an 18-bit signed sum to a Q1.15 sample
   function automatic logic [SW-1:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'h7FFF;
      end else if (v < -18'sd32768) begin
         return 16'h8000;
      end else begin
         return v[SW-1:0];
      end
   endfunction

   // Configuration registers
   logic [lcdl_pkg::INC_W-1:0]    inc_ff, inc_in;
   logic [lcdl_pkg::DLYCFG_W-1:0] base_ff, base_in;
   logic [lcdl_pkg::DLYCFG_W-1:0] depth_ff, depth_in;
   logic [lcdl_pkg::WET_W-1:0]    wet_ff, wet_in;
   logic [lcdl_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic                          on_ff, on_in;

   // Control and persistent state
   lcdl_pkg::state_type            state_ff, state_in;
   logic [lcdl_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [ADDR_W-1:0]              wp_ff, wp_in;
   logic                           wrapped_ff, wrapped_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [SW-1:0]           x_ff, x_in;
   logic signed [AW-1:0]           opa_ff, opa_in;
   lcdl_pkg::mul_op_type           mop_ff, mop_in;
   logic signed [AW-1:0]           a_ff, a_in;
   logic signed [A3W-1:0]          a3_ff, a3_in;
   logic [BW-1:0]                  b_ff, b_in;
   logic [lcdl_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic [DLY_W-1:0]               dly_ff, dly_in;
   logic signed [SW-1:0]           tap1_ff, tap1_in;
   logic signed [SW-1:0]           tap_ff, tap_in;
   logic signed [SW-1:0]           res_ff, res_in;
   logic signed [SW-1:0]           rsp_data_ff, rsp_data_in;

   // Delay ring
   logic signed [SW-1:0]           ring [DELAY_DEPTH];
   logic signed [SW-1:0]           rd_data_ff;
   logic                           rd_valid_ff;
   logic [ADDR_W-1:0]              rd_addr;
   logic                           ring_we;
   logic signed [SW-1:0]           ring_wdata;

   // Quarter-wave sine table
   logic [lcdl_pkg::SINE_MAG_W-1:0] sine_rom [SINE_QTR];

   for (genvar gi = 0; gi < SINE_QTR; gi++) begin : g_sine
      assign sine_rom[gi] = lcdl_pkg::sine_mag(gi, LOG2N);
   end

   // Combinational helpers
   logic                                req_xfer;
   logic [LOG2N-1:0]                    sin_idx;
   logic [QTR_W-1:0]                    sin_low;
   logic [QTR_W-1:0]                    sin_qidx;
   logic [lcdl_pkg::SINE_MAG_W-1:0]     sin_mag;
   logic signed [AW-1:0]                sin_val;
   logic signed [SW-1:0]                rd_tap;
   logic [ADDR_W-1:0]                   p1, p2;
   logic [lcdl_pkg::WET_W-1:0]          wet_sat;
   logic signed [ACC_W-1:0]             addend;
   logic signed [ACC_W-1:0]             acc_q15;
   logic signed [ACC_W-1:0]             acc_r8_sum, acc_r8;
   logic signed [ACC_W-1:0]             acc_r16_sum, acc_r16;
   logic signed [SUM_W-1:0]             base_s, mod_s, dsum;
   logic signed [17:0]                  tap_wide, buf_wide, y_wide;

   assign req_xfer       = req_valid && !req_stall;
   assign req_stall      = reset || (state_ff != lcdl_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // Look up the sine point for the current phase, folding the quarter wave
   always_comb begin
      sin_idx  = phase_ff[lcdl_pkg::PHASE_W-1 -: LOG2N];
      sin_low  = sin_idx[QTR_W-1:0];
      sin_qidx = sin_idx[LOG2N-2] ? (QTR_W'(0) - sin_low) : sin_low;
      if (sin_idx[LOG2N-2] && (sin_low == '0)) begin
         sin_mag = SINE_PEAK;
      end else begin
         sin_mag = sine_rom[sin_qidx];
      end
      if (sin_idx[LOG2N-1]) begin
         sin_val = AW'(0) - {2'b00, sin_mag};
      end else begin
         sin_val = {2'b00, sin_mag};
      end
   end

   // Arithmetic around the multiplier and the ring
   always_comb begin
      rd_tap  = rd_valid_ff ? rd_data_ff : '0;
      p1      = wp_ff - dly_ff[DLY_W-1:8];
      p2      = p1 - ADDR_W'(1);
      rd_addr = (state_ff == lcdl_pkg::ST_RD2) ? p2 : p1;
      wet_sat = (wet_ff > lcdl_pkg::WET_FULL) ? lcdl_pkg::WET_FULL : wet_ff;

      case (b_ff[BW-1 -: 2])
         2'd1:    addend = {{(ACC_W-AW){a_ff[AW-1]}}, a_ff};
         2'd2:    addend = {{(ACC_W-AW-1){a_ff[AW-1]}}, a_ff, 1'b0};
         2'd3:    addend = {{(ACC_W-A3W){a3_ff[A3W-1]}}, a3_ff};
         default: addend = '0;
      endcase

      acc_q15     = acc_ff >>> 15;
      acc_r8_sum  = acc_ff + RND8;
      acc_r8      = acc_r8_sum >>> 8;
      acc_r16_sum = acc_ff + RND16;
      acc_r16     = acc_r16_sum >>> 16;

      base_s = {{(SUM_W-lcdl_pkg::DLYCFG_W){1'b0}}, base_ff};
      mod_s  = acc_q15[SUM_W-1:0];
      dsum   = base_s + mod_s;

      tap_wide = {{2{tap1_ff[SW-1]}}, tap1_ff} + acc_r8[17:0];
      buf_wide = {{2{x_ff[SW-1]}}, x_ff} + acc_r16[17:0];
      y_wide   = {{2{x_ff[SW-1]}}, x_ff} + acc_r16[17:0];
   end

   // Next state and register updates
   always_comb begin
      inc_in       = inc_ff;
      base_in      = base_ff;
      depth_in     = depth_ff;
      wet_in       = wet_ff;
      gain_in      = gain_ff;
      on_in        = on_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      x_in         = x_ff;
      opa_in       = opa_ff;
      mop_in       = mop_ff;
      a_in         = a_ff;
      a3_in        = a3_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      dly_in       = dly_ff;
      tap1_in      = tap1_ff;
      tap_in       = tap_ff;
      res_in       = res_ff;
      ring_we      = 1'b0;
      ring_wdata   = sat16(buf_wide);

      // Configuration writes
      if (csr_write_en) begin
         case (csr_index)
            lcdl_pkg::CSR_PHASE_INC: inc_in   = csr_data[lcdl_pkg::INC_W-1:0];
            lcdl_pkg::CSR_BASE_DLY:  base_in  = csr_data[lcdl_pkg::DLYCFG_W-1:0];
            lcdl_pkg::CSR_MOD_DEPTH: depth_in = csr_data[lcdl_pkg::DLYCFG_W-1:0];
            lcdl_pkg::CSR_WET_MIX:   wet_in   = csr_data[lcdl_pkg::WET_W-1:0];
            lcdl_pkg::CSR_FBK_GAIN:  gain_in  = csr_data[lcdl_pkg::GAIN_W-1:0];
            lcdl_pkg::CSR_EFFECT_ON: on_in    = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         // Take a sample; advance the phase or pass the sample through
         lcdl_pkg::ST_IDLE: begin
            if (req_xfer) begin
               x_in = req_sample_in;
               if (on_ff) begin
                  phase_in = phase_ff + {{(lcdl_pkg::PHASE_W-lcdl_pkg::INC_W){1'b0}}, inc_ff};
                  state_in = lcdl_pkg::ST_SINE;
               end else begin
                  res_in   = req_sample_in;
                  state_in = lcdl_pkg::ST_OUT;
               end
            end
         end
         lcdl_pkg::ST_SINE: begin
            opa_in   = sin_val;
            mop_in   = lcdl_pkg::MOP_MOD;
            state_in = lcdl_pkg::ST_LOAD;
         end
         // Load the multiplier: multiplicand and its triple, left-aligned multiplier
         lcdl_pkg::ST_LOAD: begin
            acc_in = '0;
            a_in   = opa_ff;
            a3_in  = {{2{opa_ff[AW-1]}}, opa_ff} + {opa_ff[AW-1], opa_ff, 1'b0};
            case (mop_ff)
               lcdl_pkg::MOP_MOD: begin
                  b_in   = depth_ff;
                  cnt_in = lcdl_pkg::MOD_DIGITS;
               end
               lcdl_pkg::MOP_INTERP: begin
                  b_in   = {dly_ff[7:0], 12'b0};
                  cnt_in = lcdl_pkg::INTERP_DIGITS;
               end
               lcdl_pkg::MOP_FBK: begin
                  b_in   = {gain_ff, 4'b0};
                  cnt_in = lcdl_pkg::FBK_DIGITS;
               end
               default: begin
                  b_in   = {1'b0, wet_sat, 2'b0};
                  cnt_in = lcdl_pkg::MIX_DIGITS;
               end
            endcase
            state_in = lcdl_pkg::ST_MUL;
         end
         // One radix-4 digit per cycle, most significant first
         lcdl_pkg::ST_MUL: begin
            acc_in = {acc_ff[ACC_W-3:0], 2'b00} + addend;
            b_in   = {b_ff[BW-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == lcdl_pkg::MUL_CNT_W'(1)) begin
               case (mop_ff)
                  lcdl_pkg::MOP_MOD:    state_in = lcdl_pkg::ST_DELAY;
                  lcdl_pkg::MOP_INTERP: state_in = lcdl_pkg::ST_TAP;
                  lcdl_pkg::MOP_FBK:    state_in = lcdl_pkg::ST_FBK;
                  default:              state_in = lcdl_pkg::ST_MIX;
               endcase
            end
         end
         // Clamp the modulated delay
         lcdl_pkg::ST_DELAY: begin
            if (dsum[SUM_W-1]) begin
               dly_in = '0;
            end else if (dsum > DMAX) begin
               dly_in = DMAX[DLY_W-1:0];
            end else begin
               dly_in = dsum[DLY_W-1:0];
            end
            state_in = lcdl_pkg::ST_RD1;
         end
         lcdl_pkg::ST_RD1: begin
            state_in = lcdl_pkg::ST_RD2;
         end
         lcdl_pkg::ST_RD2: begin
            tap1_in  = rd_tap;
            state_in = lcdl_pkg::ST_DIFF;
         end
         lcdl_pkg::ST_DIFF: begin
            opa_in   = {rd_tap[SW-1], rd_tap} - {tap1_ff[SW-1], tap1_ff};
            mop_in   = lcdl_pkg::MOP_INTERP;
            state_in = lcdl_pkg::ST_LOAD;
         end
         // Finish the interpolated tap
         lcdl_pkg::ST_TAP: begin
            tap_in   = tap_wide[SW-1:0];
            opa_in   = {tap_wide[SW-1], tap_wide[SW-1:0]};
            mop_in   = lcdl_pkg::MOP_FBK;
            state_in = lcdl_pkg::ST_LOAD;
         end
         // Write the fed-back sample and advance the pointer
         lcdl_pkg::ST_FBK: begin
            ring_we  = 1'b1;
            wp_in    = wp_ff + ADDR_W'(1);
            if (wp_ff == '1) begin
               wrapped_in = 1'b1;
            end
            opa_in   = {tap_ff[SW-1], tap_ff} - {x_ff[SW-1], x_ff};
            mop_in   = lcdl_pkg::MOP_MIX;
            state_in = lcdl_pkg::ST_LOAD;
         end
         lcdl_pkg::ST_MIX: begin
            res_in   = sat16(y_wide);
            state_in = lcdl_pkg::ST_OUT;
         end
         // Hold until the output register is free
         lcdl_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lcdl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcdl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdl_pkg::ST_IDLE;
         inc_ff       <= '0;
         base_ff      <= '0;
         depth_ff     <= '0;
         wet_ff       <= '0;
         gain_ff      <= '0;
         on_ff        <= 1'b0;
         phase_ff     <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inc_ff       <= inc_in;
         base_ff      <= base_in;
         depth_ff     <= depth_in;
         wet_ff       <= wet_in;
         gain_ff      <= gain_in;
         on_ff        <= on_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      opa_ff      <= opa_in;
      mop_ff      <= mop_in;
      a_ff        <= a_in;
      a3_ff       <= a3_in;
      b_ff        <= b_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      dly_ff      <= dly_in;
      tap1_ff     <= tap1_in;
      tap_ff      <= tap_in;
      res_ff      <= res_in;
   end

   // Ring: one write and one registered read per cycle; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[wp_ff] <= ring_wdata;
      end
      rd_data_ff  <= ring[rd_addr];
      rd_valid_ff <= wrapped_ff || (rd_addr < wp_ff);
   end

endmodule

`default_nettype wire

[rtl/lcdl_checker.sv]
// Port-level checker for the chorus delay line, bound to the top level.
`default_nettype none

module lcdl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [lcdl_pkg::SAMPLE_W-1:0]    rsp_sample_out
);

   // A stalled result stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed or dropped");

   // One item at a time: a transfer in is followed by a stalled input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second input transfer while an item is in work");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new result appears only while the input side is busy with its item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

endmodule

bind lfo_chorus_delay_line_unit lcdl_checker u_lcdl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

`default_nettype wire

[tb/sv/tb_lfo_chorus_delay_line_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the chorus delay line: directed table, then random phases.

module tb_lfo_chorus_delay_line_unit;
   import lcdl_pkg::*;

   localparam int unsigned RING_DEPTH = DELAY_DEPTH_DEF;
   localparam int unsigned LUT_SIZE   = SINE_ENTRIES_DEF;
   localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
   localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
   localparam longint      DELAY_MAX  = longint'(RING_DEPTH - 2) * 256;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

   typedef struct {
      row_kind_t                   kind;
      csr_index_type               idx;
      logic [CSR_DATA_W-1:0]       data;
      logic signed [SAMPLE_W-1:0]  smp;
      bit                          given;
      logic signed [SAMPLE_W-1:0]  want;
   } stim_row_t;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_W-1:0]    req_sample_in;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_sample_out;
   logic                          csr_write_en;
   csr_index_type                 csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   // Shadow copy of the chorus state and its settings
   logic [INC_W-1:0]              cfg_phase_inc;
   logic [DLYCFG_W-1:0]           cfg_base_delay;
   logic [DLYCFG_W-1:0]           cfg_mod_depth;
   logic [WET_W-1:0]              cfg_wet_mix;
   logic [GAIN_W-1:0]             cfg_fbk_gain;
   logic                          cfg_effect_on;
   logic signed [SAMPLE_W-1:0]    delay_ring [0:RING_DEPTH-1];
   logic [RING_AW-1:0]            ring_wp;
   logic [PHASE_W-1:0]            lfo_phase;
   int                            sine_lut [0:LUT_SIZE-1];

   logic signed [SAMPLE_W-1:0]    expected_out_q [$];
   stim_row_t                     plan_q [$];
   int unsigned                   fail_count = 0;
   bit                            quiet_run = 1'b0;

   lfo_chorus_delay_line_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no idling, some short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Delay setting in samples Q.8: zero, short, medium, anywhere, or the top code
   function automatic logic [DLYCFG_W-1:0] delay_cfg();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return $urandom_range(0, 16'h1000);
         2: return $urandom_range(0, 20'h20000);
         3: return $urandom;
         default: return '1;
      endcase
   endfunction

   // Advance the shadow chorus by one sample and return the mixed output
   function automatic logic signed [SAMPLE_W-1:0] chorus_step(
      input logic signed [SAMPLE_W-1:0] x);
      longint             xs, md, dly, frac, t1, t2, tap, g, fbk_sum, wet, mix;
      logic [RING_AW-1:0] dint, p1, p2;
      xs = x;
      if (!cfg_effect_on) return x;

      lfo_phase = lfo_phase + cfg_phase_inc;
      md = cfg_mod_depth;
      dly = cfg_base_delay;
      dly = dly + ((md * sine_lut[lfo_phase[PHASE_W-1 -: $clog2(LUT_SIZE)]]) >>> 15);
      if (dly < 0) dly = 0;
      if (dly > DELAY_MAX) dly = DELAY_MAX;
      dint = dly[RING_AW+7:8];
      frac = dly & 255;

      // Interpolate between the two taps; a zero delay reads the slot about to be written
      p1 = ring_wp - dint;
      p2 = ring_wp - dint - 1'b1;
      t1 = delay_ring[p1];
      t2 = delay_ring[p2];
      tap = (t1 * (256 - frac) + t2 * frac + 128) >>> 8;

      // Feed back into the ring with saturation
      g = cfg_fbk_gain;
      fbk_sum = xs + ((tap * g + 32768) >>> 16);
      if (fbk_sum > 32767) fbk_sum = 32767;
      if (fbk_sum < -32768) fbk_sum = -32768;
      delay_ring[ring_wp] = fbk_sum[SAMPLE_W-1:0];
      ring_wp = ring_wp + 1'b1;

      // Dry/wet mix, wet share saturated at fully wet
      wet = (cfg_wet_mix > WET_FULL) ? longint'(WET_FULL) : longint'(cfg_wet_mix);
      mix = (xs * (65536 - wet) + tap * wet + 32768) >>> 16;
      if (mix > 32767) mix = 32767;
      if (mix < -32768) mix = -32768;
      return mix[SAMPLE_W-1:0];
   endfunction

   function automatic void add_write(input csr_index_type idx,
                                     input logic [CSR_DATA_W-1:0] data);
      stim_row_t row;
      row = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
      plan_q.push_back(row);
   endfunction

   function automatic void add_sample(input logic signed [SAMPLE_W-1:0] smp,
                                      input bit given = 1'b0,
                                      input logic signed [SAMPLE_W-1:0] want = '0);
      stim_row_t row;
      row = '{ROW_SAMPLE, CSR_PHASE_INC, '0, smp, given, want};
      plan_q.push_back(row);
   endfunction

   // Write one register once all outstanding results have drained
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      case (idx)
         CSR_PHASE_INC: cfg_phase_inc  = data[INC_W-1:0];
         CSR_BASE_DLY:  cfg_base_delay = data[DLYCFG_W-1:0];
         CSR_MOD_DEPTH: cfg_mod_depth  = data[DLYCFG_W-1:0];
         CSR_WET_MIX:   cfg_wet_mix    = data[WET_W-1:0];
         CSR_FBK_GAIN:  cfg_fbk_gain   = data[GAIN_W-1:0];
         CSR_EFFECT_ON: cfg_effect_on  = data[0];
         default: ;
      endcase
   endtask

   // Offer one sample, hold it until the transfer, then queue its expected output
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                              input bit given,
                              input logic signed [SAMPLE_W-1:0] want);
      int unsigned                gap;
      logic signed [SAMPLE_W-1:0] pred;
      gap = quiet_run ? 0 : idle_len();
      csr_write_en <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= smp;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pred = chorus_step(smp);
      expected_out_q.push_back(given ? want : pred);
   endtask

   // Result side: check each transfer, then pick the next stall pattern
   always @(posedge clock) begin : rsp_side
      logic signed [SAMPLE_W-1:0] want;
      int unsigned                stall_left;
      bit                         stall_now;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_out_q.size() == 0) begin
            $display("%0t: unexpected result, got %0d", $time, rsp_sample_out);
            fail_count++;
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_sample_out !== want) begin
               $display("%0t: sample_out mismatch, expected %0d, got %0d",
                        $time, want, rsp_sample_out);
               fail_count++;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left--;
      end else begin
         stall_now  = !quiet_run && ($urandom_range(0, 1) == 1);
         stall_left = idle_len();
      end
      rsp_stall <= stall_now;
   end

   initial begin
      logic [63:0]                ang, rad, rad2, term;
      longint                     acc, mag;
      bit                         neg;
      logic signed [SAMPLE_W-1:0] smp;
      logic [CSR_DATA_W-1:0]      eff, wet, gain;
      int unsigned                n_items;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_PHASE_INC;
      csr_data      = '0;

      // Shadow state as it stands after reset
      cfg_phase_inc  = '0;
      cfg_base_delay = '0;
      cfg_mod_depth  = '0;
      cfg_wet_mix    = '0;
      cfg_fbk_gain   = '0;
      cfg_effect_on  = 1'b0;
      ring_wp        = '0;
      lfo_phase      = '0;
      foreach (delay_ring[j]) delay_ring[j] = '0;

      // Sine table from a Taylor series over the first quarter wave
      for (int i = 0; i < LUT_SIZE; i++) begin
         ang = 64'(i) << (32 - $clog2(LUT_SIZE));
         neg = (ang >= 64'h8000_0000);
         if (neg) ang = ang - 64'h8000_0000;
         if (ang > 64'h4000_0000) ang = 64'h8000_0000 - ang;
         rad  = (ang * TWO_PI_Q29) >> 31;
         rad2 = (rad * rad) >> 30;
         term = rad;
         acc  = longint'(rad);
         for (int k = 1; k <= 6; k++) begin
            term = ((term * rad2) >> 30) / 64'(4 * k * k + 2 * k);
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         if (acc < 0) acc = 0;
         mag = (acc + 16384) >>> 15;
         if (mag > 32767) mag = 32767;
         sine_lut[i] = neg ? -int'(mag) : int'(mag);
      end

      // Directed table
      // pass-through right after reset
      add_sample(16'sh7FFF, 1'b1, 16'sh7FFF);
      add_sample(16'sh8000, 1'b1, 16'sh8000);
      add_sample(16'sh0000, 1'b1, 16'sh0000);
      add_sample(-16'sd1, 1'b1, -16'sd1);
      // effect on, fully dry
      add_write(CSR_EFFECT_ON, 20'd1);
      add_sample(16'sh7FFF, 1'b1, 16'sh7FFF);
      add_sample(16'sh8000, 1'b1, 16'sh8000);
      // fully wet with zero delay reads the slot about to be overwritten
      add_write(CSR_WET_MIX, 20'd65536);
      add_sample(16'sd12345, 1'b1, 16'sd0);
      // one sample of delay returns the previous input
      add_write(CSR_BASE_DLY, 20'd256);
      add_sample(-16'sd4000, 1'b1, 16'sd12345);
      add_sample(16'sd20000);
      // fractional delay
      add_write(CSR_BASE_DLY, 20'h00180);
      add_sample(16'sd1000);
      add_sample(-16'sd1000);
      // strongest feedback drives the ring into saturation; wet share above full
      add_write(CSR_FBK_GAIN, 20'd62259);
      add_write(CSR_BASE_DLY, 20'd256);
      add_write(CSR_WET_MIX, 20'h1FFFF);
      repeat (4) add_sample(16'sh7FFF);
      repeat (3) add_sample(16'sh8000);
      // gain above the usual limit is used as given
      add_write(CSR_FBK_GAIN, 20'h0FFFF);
      repeat (2) add_sample(16'sh7FFF);
      // delay far past the ring clamps to its top
      add_write(CSR_BASE_DLY, 20'hFFFFF);
      add_sample(16'sd100);
      // deepest, fastest modulation around a zero base
      add_write(CSR_MOD_DEPTH, 20'hFFFFF);
      add_write(CSR_PHASE_INC, 20'hFFFFF);
      add_write(CSR_BASE_DLY, 20'd0);
      add_write(CSR_WET_MIX, 20'd32768);
      add_sample(16'sd3);
      add_sample(-16'sd7777);
      // disabled again: pass through, state held
      add_write(CSR_EFFECT_ON, 20'd0);
      add_sample(16'sh8000, 1'b1, 16'sh8000);
      add_sample(16'sd12, 1'b1, 16'sd12);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == ROW_WRITE) write_reg(plan_q[i].idx, plan_q[i].data);
         else send_sample(plan_q[i].smp, plan_q[i].given, plan_q[i].want);
      end

      // Random phases; fast LFO in most of them so the phase crosses into the negative half
      for (int ph = 0; ph < 18; ph++) begin
         quiet_run = (ph % 4 == 3);
         if (ph == 0) write_reg(CSR_PHASE_INC, 20'd0);
         else if (ph == 1) write_reg(CSR_PHASE_INC, $urandom_range(1, 12'hFFF));
         else if (ph == 17) write_reg(CSR_PHASE_INC, 20'hFFFFF);
         else write_reg(CSR_PHASE_INC, $urandom_range(20'hF0000, 20'hFFFFF));
         write_reg(CSR_BASE_DLY, delay_cfg());
         write_reg(CSR_MOD_DEPTH, delay_cfg());
         case ($urandom_range(0, 4))
            0: wet = '0;
            1: wet = 20'd65536;
            2: wet = $urandom_range(0, 65536);
            3: wet = $urandom_range(65537, 131071);
            default: wet = $urandom;
         endcase
         write_reg(CSR_WET_MIX, wet);
         case ($urandom_range(0, 3))
            0: gain = '0;
            1: gain = 20'd62259;
            2: gain = $urandom_range(0, 62259);
            default: gain = $urandom;
         endcase
         write_reg(CSR_FBK_GAIN, gain);
         // upper data bits of the enable are don't-care
         eff    = $urandom;
         eff[0] = (ph != 5 && ph != 11);
         write_reg(CSR_EFFECT_ON, eff);
         n_items = eff[0] ? 190 : 40;
         repeat (n_items) begin
            case ($urandom_range(0, 9))
               0: smp = 16'sh7FFF;
               1: smp = 16'sh8000;
               2: smp = $urandom_range(0, 64) - 32;
               default: smp = $urandom;
            endcase
            send_sample(smp, 1'b0, '0);
         end
      end

      // Drain, then allow for any stray late result
      req_valid <= 1'b0;
      quiet_run = 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
